FILE: src/gemf_pkg.sv
// Shared constants, types and helper functions for the grayscale erosion filter.
// Used by gemf_front, gemf_cell, grayscale_erosion_min_filter and the bench files; depends on nothing.
package gemf_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int MAX_PASSES = 4;

	localparam int PIX_W  = 8;
	localparam int DIM_W  = 11;
	localparam int PCNT_W = 3;
	localparam int IDX_W  = 2;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);
	localparam int PASS_W = (MAX_PASSES > 1) ? $clog2(MAX_PASSES) : 1;

	localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};

	localparam logic FUNC_FLUSH = 1'b1;

	typedef enum logic [IDX_W-1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_PASSES = 2'd2
	} gemf_reg_t;

	typedef struct packed {
		logic [DIM_W-1:0]  width;
		logic [DIM_W-1:0]  height;
		logic [PCNT_W-1:0] passes;
	} gemf_cfg_t;

	// One token per accepted item travels down the chain; carry marks a pixel.
	typedef struct packed {
		logic             valid;
		logic             carry;
		logic             last;
		logic [PIX_W-1:0] value;
	} gemf_tok_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] hi);
		logic [DIM_W-1:0] r;
		r = v;
		if (v < DIM_W'(2)) begin
			r = DIM_W'(2);
		end else if (v > hi) begin
			r = hi;
		end
		return r;
	endfunction

	function automatic logic [PCNT_W-1:0] clamp_passes(input logic [PCNT_W-1:0] v);
		logic [PCNT_W-1:0] r;
		r = v;
		if (v < PCNT_W'(1)) begin
			r = PCNT_W'(1);
		end else if (v > PCNT_W'(MAX_PASSES)) begin
			r = PCNT_W'(MAX_PASSES);
		end
		return r;
	endfunction

	function automatic logic [PIX_W-1:0] min3(input logic [PIX_W-1:0] a,
			input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] c);
		logic [PIX_W-1:0] m;
		m = (a < b) ? a : b;
		return (c < m) ? c : m;
	endfunction

endpackage

FILE: src/gemf_front.sv
// Input stage of the erosion chain: frame position tracking, pixel dropping and
// counting of the drain items that empty the chain. Depends on gemf_pkg.
module gemf_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     restart,
	input  gemf_pkg::gemf_cfg_t      cfg,
	input  logic                     valid,
	input  logic                     func,
	input  logic [gemf_pkg::PIX_W-1:0] pixel,
	output gemf_pkg::gemf_tok_t      tok
);
	import gemf_pkg::*;

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [DIM_W-1:0]  dcol_q;
	logic [PASS_W-1:0] dpass_q;
	gemf_tok_t         tok_q;

	logic take;
	logic full;
	logic carry;
	logic last_col;
	logic last_pass;

	assign take      = valid && en;
	assign full      = (row_q == ROW_W'(cfg.height));
	assign carry     = (func != FUNC_FLUSH) && !full;
	assign last_col  = (DIM_W'(col_q) == cfg.width - DIM_W'(1));
	assign last_pass = (PCNT_W'(dpass_q) == cfg.passes - PCNT_W'(1));
	assign tok       = tok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			dcol_q  <= '0;
			dpass_q <= '0;
			tok_q   <= '0;
		end else begin
			if (restart) begin
				col_q   <= '0;
				row_q   <= '0;
				dcol_q  <= '0;
				dpass_q <= '0;
			end else if (take) begin
				if (!full) begin
					if (carry) begin
						if (last_col) begin
							col_q <= '0;
							row_q <= row_q + ROW_W'(1);
						end else begin
							col_q <= col_q + COL_W'(1);
						end
					end
				end else if (dcol_q == cfg.width) begin
					// Each pass needs one row plus one item to empty; the frame ends
					// once every pass has been emptied.
					dcol_q <= '0;
					if (last_pass) begin
						dpass_q <= '0;
						col_q   <= '0;
						row_q   <= '0;
					end else begin
						dpass_q <= dpass_q + PASS_W'(1);
					end
				end else begin
					dcol_q <= dcol_q + DIM_W'(1);
				end
			end
			if (en) begin
				tok_q.valid <= take;
				tok_q.carry <= take && carry;
				tok_q.last  <= 1'b0;
				tok_q.value <= pixel;
			end
		end
	end

endmodule

FILE: src/gemf_cell.sv
// One 3x3 minimum pass: a two-line store, a column minimum and a row minimum.
// Identical cells are chained; depends on gemf_pkg.
module gemf_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                restart,
	input  gemf_pkg::gemf_cfg_t cfg,
	input  gemf_pkg::gemf_tok_t tok_in,
	output gemf_pkg::gemf_tok_t tok_out
);
	import gemf_pkg::*;

	// Position of the next stream item; rows at and beyond the height are
	// virtual items that push out the bottom of the frame.
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	logic             valid_s1;
	logic             adv_s1;
	logic             emit_s1;
	logic             last_s1;
	logic             bot_s1;
	logic             top_s1;
	logic             left_s1;
	logic             right_s1;
	logic [PIX_W-1:0] x_s1;
	logic [COL_W-1:0] addr_s1;

	logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
	logic [2*PIX_W-1:0] rd_q;

	logic [PIX_W-1:0] v0_q;
	logic [PIX_W-1:0] v1_q;
	gemf_tok_t        tok_q;

	logic             adv;
	logic             at_end;
	logic             last_col;
	logic             emit;
	logic [PIX_W-1:0] vmin;
	logic [PIX_W-1:0] hmin;

	assign adv      = tok_in.valid && (tok_in.carry || (row_q >= ROW_W'(cfg.height)));
	assign at_end   = (row_q == ROW_W'(cfg.height) + ROW_W'(1));
	assign last_col = (DIM_W'(col_q) == cfg.width - DIM_W'(1));
	assign emit     = adv && ((row_q >= ROW_W'(2)) ||
			((row_q == ROW_W'(1)) && (col_q != '0)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
			adv_s1   <= 1'b0;
			emit_s1  <= 1'b0;
			last_s1  <= 1'b0;
		end else begin
			if (restart) begin
				col_q <= '0;
				row_q <= '0;
			end else if (en && adv) begin
				if (at_end) begin
					col_q <= '0;
					row_q <= '0;
				end else if (last_col) begin
					col_q <= '0;
					row_q <= row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
			if (en) begin
				valid_s1 <= tok_in.valid;
				adv_s1   <= adv;
				emit_s1  <= emit;
				last_s1  <= adv && at_end;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1     <= tok_in.value;
			addr_s1  <= col_q;
			bot_s1   <= tok_in.carry;
			top_s1   <= (row_q >= ROW_W'(2));
			left_s1  <= (col_q != COL_W'(1));
			right_s1 <= (col_q != '0);
		end
	end

	// Each entry holds the items one and two rows back at that column.
	always_ff @(posedge clk) begin
		if (en && adv) begin
			rd_q <= line_mem[col_q];
		end
		if (en && adv_s1) begin
			line_mem[addr_s1] <= {x_s1, rd_q[2*PIX_W-1:PIX_W]};
		end
	end

	always_comb begin
		vmin = min3(bot_s1 ? x_s1 : PIX_MAX, rd_q[2*PIX_W-1:PIX_W],
				top_s1 ? rd_q[PIX_W-1:0] : PIX_MAX);
		hmin = min3(left_s1 ? v1_q : PIX_MAX, v0_q, right_s1 ? vmin : PIX_MAX);
	end

	always_ff @(posedge clk) begin
		if (en && adv_s1) begin
			v0_q <= vmin;
			v1_q <= v0_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (en) begin
			tok_q.valid <= valid_s1;
			tok_q.carry <= emit_s1;
			tok_q.last  <= last_s1;
			tok_q.value <= hmin;
		end
	end

	assign tok_out = tok_q;

endmodule

FILE: src/grayscale_erosion_min_filter.sv
// Top level of the cascaded 3x3 grayscale erosion filter: configuration registers,
// input stage, chain of erosion cells and result register. Depends on gemf_pkg.
// Items pass the input stage, the two registers of each active cell and the result register
// in turn; throughput is one item per cycle while the result is not stalled, set by the one
// read and one write per cycle of the line store in each cell. A stalled result freezes the whole chain.
// Reset restores the register defaults and clears all counters; line stores are not cleared.
module grayscale_erosion_min_filter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [gemf_pkg::IDX_W-1:0]  cfg_index,
	input  logic [gemf_pkg::DIM_W-1:0]  cfg_data,
	input  logic                        feed_valid,
	output logic                        feed_stall,
	input  logic                        func,
	input  logic [gemf_pkg::PIX_W-1:0]  pixel,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic [gemf_pkg::PIX_W-1:0]  eroded_pixel,
	output logic                        last_of_frame
);
	import gemf_pkg::*;

	gemf_cfg_t        cfg_q;
	logic             res_valid_q;
	logic [PIX_W-1:0] eroded_q;
	logic             last_q;

	logic             en;
	logic             restart;
	gemf_tok_t        front_tok;
	gemf_tok_t        cell_tok [MAX_PASSES];
	gemf_tok_t        sel_tok;
	logic [PASS_W-1:0] sel;

	assign en         = !res_valid_q || !result_stall;
	assign feed_stall = !en;

	always_comb begin
		case (cfg_index)
			REG_WIDTH:  restart = cfg_we;
			REG_HEIGHT: restart = cfg_we;
			REG_PASSES: restart = cfg_we;
			default:    restart = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= DIM_W'(MAX_WIDTH);
			cfg_q.height <= DIM_W'(MAX_HEIGHT);
			cfg_q.passes <= PCNT_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:  cfg_q.width  <= clamp_dim(cfg_data, DIM_W'(MAX_WIDTH));
				REG_HEIGHT: cfg_q.height <= clamp_dim(cfg_data, DIM_W'(MAX_HEIGHT));
				REG_PASSES: cfg_q.passes <= clamp_passes(cfg_data[PCNT_W-1:0]);
				default:    cfg_q        <= cfg_q;
			endcase
		end
	end

	gemf_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.restart (restart),
		.cfg     (cfg_q),
		.valid   (feed_valid),
		.func    (func),
		.pixel   (pixel),
		.tok     (front_tok)
	);

	for (genvar i = 0; i < MAX_PASSES; i++) begin : g_cell
		if (i == 0) begin : g_first
			gemf_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.en      (en),
				.restart (restart),
				.cfg     (cfg_q),
				.tok_in  (front_tok),
				.tok_out (cell_tok[i])
			);
		end else begin : g_next
			gemf_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.en      (en),
				.restart (restart),
				.cfg     (cfg_q),
				.tok_in  (cell_tok[i-1]),
				.tok_out (cell_tok[i])
			);
		end
	end

	// Results are taken from the last active pass; later cells still run, but their output is unused.
	assign sel     = PASS_W'(cfg_q.passes - PCNT_W'(1));
	assign sel_tok = cell_tok[sel];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en) begin
			res_valid_q <= sel_tok.valid && sel_tok.carry;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			eroded_q <= sel_tok.value;
			last_q   <= sel_tok.last;
		end
	end

	assign result_valid  = res_valid_q;
	assign eroded_pixel  = eroded_q;
	assign last_of_frame = last_q;

endmodule

FILE: bench/gemf_erosion_check.sv
// Checker for the grayscale erosion filter: watches the register port and both item
// channels, predicts every eroded pixel and compares it with what the block gives out.
// Depends on gemf_pkg for widths, register indexes and the flush code.
module gemf_erosion_check (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [gemf_pkg::IDX_W-1:0]  cfg_index,
	input  logic [gemf_pkg::DIM_W-1:0]  cfg_data,
	input  logic                        feed_valid,
	input  logic                        feed_stall,
	input  logic                        func,
	input  logic [gemf_pkg::PIX_W-1:0]  pixel,
	input  logic                        result_valid,
	input  logic                        result_stall,
	input  logic [gemf_pkg::PIX_W-1:0]  eroded_pixel,
	input  logic                        last_of_frame,
	output int                          outstanding,
	output int                          failures
);
	timeunit 1ns;
	timeprecision 1ps;

	import gemf_pkg::*;

	localparam int STORE_D = 2 * MAX_WIDTH + 3;

	typedef struct packed {
		logic [PIX_W-1:0] value;
		logic             last;
	} eroded_t;

	// Per-stage circular store of the most recent inputs and the frame counters.
	logic [PIX_W-1:0]  line_mem [MAX_PASSES][STORE_D];
	int unsigned       wr_ptr   [MAX_PASSES];
	int unsigned       taken    [MAX_PASSES];
	int unsigned       given    [MAX_PASSES];
	int unsigned       row_pos  [MAX_PASSES];
	int unsigned       col_pos  [MAX_PASSES];
	int unsigned       frame_out;
	logic [DIM_W-1:0]  cols;
	logic [DIM_W-1:0]  rows;
	logic [PCNT_W-1:0] stages;

	eroded_t expected_pixels [$];
	eroded_t want;
	eroded_t next_exp;
	bit      produced;
	int      waiting = 0;
	int      mismatch_count = 0;

	assign outstanding = waiting;
	assign failures    = mismatch_count;

	task automatic report(input string what, input logic [PIX_W-1:0] got,
			input logic [PIX_W-1:0] exp_val);
		$display("%0t erosion check: %s got %0h, expected %0h", $realtime, what, got, exp_val);
		mismatch_count++;
	endtask

	function automatic void restart_frame();
		for (int s = 0; s < MAX_PASSES; s++) begin
			wr_ptr[s]  = 0;
			taken[s]   = 0;
			given[s]   = 0;
			row_pos[s] = 0;
			col_pos[s] = 0;
		end
		frame_out = 0;
	endfunction

	function automatic logic [DIM_W-1:0] fit_dim(input int unsigned v, input int unsigned hi);
		if (v < 2) begin
			return DIM_W'(2);
		end
		if (v > hi) begin
			return DIM_W'(hi);
		end
		return DIM_W'(v);
	endfunction

	function automatic void write_reg(input logic [IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
		int unsigned n;
		case (idx)
			REG_WIDTH: begin
				cols = fit_dim(data, MAX_WIDTH);
			end
			REG_HEIGHT: begin
				rows = fit_dim(data, MAX_HEIGHT);
			end
			REG_PASSES: begin
				n = data[PCNT_W-1:0];
				if (n < 1) begin
					n = 1;
				end else if (n > MAX_PASSES) begin
					n = MAX_PASSES;
				end
				stages = PCNT_W'(n);
			end
			default: begin
				return;
			end
		endcase
		restart_frame();
	endfunction

	// Input item idx of stage s, looked up in its circular store.
	function automatic logic [PIX_W-1:0] fetch_pixel(input int s, input int unsigned idx);
		int unsigned depth, latest, back, last_p, pos;
		depth  = 2 * int'(cols) + 3;
		latest = taken[s] - 1;
		if (idx > latest) begin
			return '0;
		end
		back = latest - idx;
		if (back >= depth) begin
			back = depth - 1;
		end
		last_p = (wr_ptr[s] == 0) ? depth - 1 : wr_ptr[s] - 1;
		pos    = (last_p >= back) ? last_p - back : last_p + depth - back;
		return line_mem[s][pos];
	endfunction

	function automatic logic [PIX_W-1:0] window_floor(input int s);
		int unsigned w, h, r, c, r0, r1, c0, c1;
		logic [PIX_W-1:0] m, v;
		w  = cols;
		h  = rows;
		r  = row_pos[s];
		c  = col_pos[s];
		r0 = (r == 0) ? 0 : r - 1;
		r1 = (r + 1 >= h) ? h - 1 : r + 1;
		c0 = (c == 0) ? 0 : c - 1;
		c1 = (c + 1 >= w) ? w - 1 : c + 1;
		m  = '1;
		for (int unsigned rr = r0; rr <= r1; rr++) begin
			for (int unsigned cc = c0; cc <= c1; cc++) begin
				v = fetch_pixel(s, rr * w + cc);
				if (v < m) begin
					m = v;
				end
			end
		end
		return m;
	endfunction

	// One accepted item through every stage; made tells whether a pixel leaves the cascade.
	function automatic void erode_step(input logic f, input logic [PIX_W-1:0] p,
			output bit made, output eroded_t res);
		int unsigned w, total, depth;
		bit carry, fire;
		logic [PIX_W-1:0] v;
		w     = cols;
		total = w * int'(rows);
		depth = 2 * w + 3;
		carry = (f != FUNC_FLUSH) && (taken[0] < total);
		v     = p;
		res   = '0;
		for (int s = 0; s < int'(stages); s++) begin
			if (carry) begin
				line_mem[s][wr_ptr[s]] = v;
				wr_ptr[s] = (wr_ptr[s] + 1 >= depth) ? 0 : wr_ptr[s] + 1;
				taken[s]++;
			end
			fire = (given[s] < total) && (taken[s] > given[s]) &&
				((taken[s] == total) || (taken[s] >= given[s] + w + 2));
			if (fire) begin
				v = window_floor(s);
				given[s]++;
				if (col_pos[s] + 1 >= w) begin
					col_pos[s] = 0;
					row_pos[s]++;
				end else begin
					col_pos[s]++;
				end
			end
			carry = fire;
		end
		made = carry;
		if (carry) begin
			frame_out++;
			res.value = v;
			res.last  = (frame_out >= total);
			if (frame_out >= total) begin
				restart_frame();
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols   = DIM_W'(MAX_WIDTH);
			rows   = DIM_W'(MAX_HEIGHT);
			stages = PCNT_W'(1);
			restart_frame();
			expected_pixels.delete();
			waiting <= 0;
		end else begin
			// A result can never stem from an item taken at the same edge.
			if (result_valid === 1'b1 && result_stall === 1'b0) begin
				if (expected_pixels.size() == 0) begin
					report("result item with nothing expected:", eroded_pixel, '0);
				end else begin
					want = expected_pixels.pop_front();
					if (eroded_pixel !== want.value) begin
						report("eroded_pixel", eroded_pixel, want.value);
					end
					if (last_of_frame !== want.last) begin
						report("last_of_frame", PIX_W'(last_of_frame), PIX_W'(want.last));
					end
				end
			end
			if (feed_valid === 1'b1 && feed_stall === 1'b0) begin
				erode_step(func, pixel, produced, next_exp);
				if (produced) begin
					expected_pixels.push_back(next_exp);
				end
			end
			if (cfg_we === 1'b1) begin
				write_reg(cfg_index, cfg_data);
			end
			waiting <= expected_pixels.size();
		end
	end

endmodule

FILE: bench/grayscale_erosion_min_filter_tb.sv
// Testbench top for the grayscale erosion filter: clock, reset, register writes and
// pixel and flush items under several idling patterns. Depends on gemf_pkg, the block
// and gemf_erosion_check, which predicts and compares the results.
module grayscale_erosion_min_filter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gemf_pkg::*;

	localparam int CLK_PERIOD      = 10;
	localparam int CYCLE_LIMIT     = 600000;
	localparam int DRAIN_CYCLES    = 2 * MAX_PASSES + 8;
	localparam int ITEMS_PER_PHASE = 160;
	localparam logic FUNC_PIXEL = ~FUNC_FLUSH;
	localparam logic [IDX_W-1:0] SPARE_INDEX = 2'd3;

	localparam int STYLE_UNIFORM = 0;
	localparam int STYLE_EXTREME = 1;
	localparam int STYLE_BRIGHT  = 2;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [IDX_W-1:0]  cfg_index = '0;
	logic [DIM_W-1:0]  cfg_data = '0;
	logic              feed_valid = 1'b0;
	logic              feed_stall;
	logic              func = FUNC_PIXEL;
	logic [PIX_W-1:0]  pixel = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	logic [PIX_W-1:0]  eroded_pixel;
	logic              last_of_frame;

	int pending_count;
	int fail_count;
	int cycles = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int phase_stall = 0;
	int items_sent = 0;
	int cur_w = MAX_WIDTH;
	int cur_h = MAX_HEIGHT;
	int cur_p = 1;

	grayscale_erosion_min_filter i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.feed_valid   (feed_valid),
		.feed_stall   (feed_stall),
		.func         (func),
		.pixel        (pixel),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.eroded_pixel (eroded_pixel),
		.last_of_frame(last_of_frame)
	);

	gemf_erosion_check i_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.feed_valid   (feed_valid),
		.feed_stall   (feed_stall),
		.func         (func),
		.pixel        (pixel),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.eroded_pixel (eroded_pixel),
		.last_of_frame(last_of_frame),
		.outstanding  (pending_count),
		.failures     (fail_count)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("grayscale_erosion_min_filter: mismatch");
			$finish;
		end
	end

	function automatic int fit_dim(input int v, input int hi);
		if (v < 2) begin
			return 2;
		end
		return (v > hi) ? hi : v;
	endfunction

	function automatic logic [PIX_W-1:0] pick_pixel(input int style);
		int sel;
		sel = $urandom_range(15);
		case (style)
			STYLE_EXTREME: begin
				if (sel < 6) begin
					return '0;
				end else if (sel < 12) begin
					return '1;
				end
				return PIX_W'($urandom_range(255));
			end
			STYLE_BRIGHT: begin
				return (sel == 0) ? PIX_W'($urandom_range(255)) : '1;
			end
			default: begin
				return PIX_W'($urandom_range(255));
			end
		endcase
	endfunction

	// Offers one item and returns at the edge that takes it.
	task automatic send(input logic f, input logic [PIX_W-1:0] p);
		while ($urandom_range(99) < idle_pct) begin
			feed_valid <= 1'b0;
			@(posedge clk);
		end
		feed_valid <= 1'b1;
		func       <= f;
		pixel      <= p;
		do @(posedge clk); while (feed_stall !== 1'b0);
	endtask

	// Waits until every predicted pixel has come out and the chain has emptied.
	task automatic settle();
		feed_valid <= 1'b0;
		stall_pct  <= 0;
		do @(posedge clk); while (pending_count != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic program_filter(input logic [DIM_W-1:0] w_data, input logic [DIM_W-1:0] h_data,
			input logic [DIM_W-1:0] p_data, input bit poke_spare);
		int n;
		cfg_we    <= 1'b1;
		cfg_index <= REG_WIDTH;
		cfg_data  <= w_data;
		@(posedge clk);
		cfg_index <= REG_HEIGHT;
		cfg_data  <= h_data;
		@(posedge clk);
		cfg_index <= REG_PASSES;
		cfg_data  <= p_data;
		@(posedge clk);
		if (poke_spare) begin
			cfg_index <= SPARE_INDEX;
			cfg_data  <= DIM_W'($urandom_range(2047));
			@(posedge clk);
		end
		cfg_we    <= 1'b0;
		stall_pct <= phase_stall;
		n     = p_data[PCNT_W-1:0];
		cur_w = fit_dim(w_data, MAX_WIDTH);
		cur_h = fit_dim(h_data, MAX_HEIGHT);
		cur_p = (n < 1) ? 1 : ((n > MAX_PASSES) ? MAX_PASSES : n);
	endtask

	// One frame of pixels followed by the flush items that drain the cascade. A noisy
	// frame also carries flushes mid-frame, pixels during the drain and may be cut short.
	task automatic run_frame(input int style, input bit noisy);
		int n_pix;
		bit cut;
		n_pix = cur_w * cur_h;
		cut   = noisy && ($urandom_range(9) == 0);
		if (cut) begin
			n_pix = $urandom_range(n_pix - 1, 1);
		end
		for (int i = 0; i < n_pix; i++) begin
			if (noisy && $urandom_range(19) == 0) begin
				send(FUNC_FLUSH, PIX_W'($urandom_range(255)));
			end
			send(FUNC_PIXEL, pick_pixel(style));
			items_sent++;
		end
		if (!cut) begin
			for (int k = 0; k < cur_p * (cur_w + 1); k++) begin
				if (noisy && $urandom_range(7) == 0) begin
					send(FUNC_PIXEL, PIX_W'($urandom_range(255)));
				end else begin
					send(FUNC_FLUSH, PIX_W'($urandom_range(255)));
				end
				items_sent++;
			end
			if (noisy && $urandom_range(3) == 0) begin
				send(FUNC_FLUSH, PIX_W'($urandom_range(255)));
			end
		end
	endtask

	initial begin
		logic [DIM_W-1:0] w_data, h_data;
		int frames;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Smallest frame with one pass: a flush before any pixel, a flush mid-frame,
		// a pixel during the drain that must be dropped, and a flush once all is out.
		program_filter(DIM_W'(2), DIM_W'(2), DIM_W'(1), 1'b1);
		send(FUNC_FLUSH, 8'h00);
		send(FUNC_PIXEL, 8'hFF);
		send(FUNC_FLUSH, 8'hFF);
		send(FUNC_PIXEL, 8'h00);
		send(FUNC_PIXEL, 8'hFF);
		send(FUNC_PIXEL, 8'hFF);
		send(FUNC_PIXEL, 8'h5A);
		send(FUNC_FLUSH, 8'hA5);
		send(FUNC_FLUSH, 8'h00);
		send(FUNC_FLUSH, 8'hFF);
		settle();

		// Out-of-range writes: width and height clamp up to two, passes to the maximum.
		program_filter(DIM_W'(1), DIM_W'(0), 11'h7FC, 1'b0);
		send(FUNC_PIXEL, 8'h80);
		send(FUNC_PIXEL, 8'h7F);
		send(FUNC_PIXEL, 8'hFF);
		send(FUNC_PIXEL, 8'h01);
		for (int k = 0; k < cur_p * (cur_w + 1); k++) begin
			send(FUNC_FLUSH, 8'h00);
		end
		settle();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					idle_pct    = 0;
					phase_stall = 0;
				end
				1: begin
					idle_pct    = 88;
					phase_stall = 0;
				end
				2: begin
					idle_pct    = 0;
					phase_stall = 88;
				end
				default: begin
					idle_pct    = 20;
					phase_stall = 20;
				end
			endcase
			items_sent = 0;
			while (items_sent < ITEMS_PER_PHASE) begin
				case ($urandom_range(9))
					0: w_data = DIM_W'($urandom_range(1));
					1: w_data = DIM_W'($urandom_range(40, 9));
					default: w_data = DIM_W'($urandom_range(8, 2));
				endcase
				case ($urandom_range(9))
					0: h_data = DIM_W'($urandom_range(1));
					1: h_data = DIM_W'($urandom_range(12, 7));
					default: h_data = DIM_W'($urandom_range(6, 2));
				endcase
				program_filter(w_data, h_data, DIM_W'($urandom_range(2047)),
					$urandom_range(3) == 0);
				frames = $urandom_range(3, 1);
				for (int f = 0; f < frames; f++) begin
					run_frame($urandom_range(STYLE_BRIGHT), $urandom_range(2) == 0);
				end
				settle();
			end
		end

		settle();
		if (fail_count == 0) begin
			$display("grayscale_erosion_min_filter: match");
		end else begin
			$display("grayscale_erosion_min_filter: mismatch");
		end
		$finish;
	end

endmodule
